>>> rtl/spf_pkg.sv
// shared types and constants for the tcp option spa finder
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

    localparam logic [7:0] KIND_SPA = 8'd253;
    localparam logic [7:0] KIND_NOP = 8'd1;
    localparam logic [7:0] KIND_EOL = 8'd0;

    localparam int OFFSET_W = 6;
    localparam int SKIP_W   = 8;

    typedef enum logic [1:0] {
        MODE_KIND = 2'd0,
        MODE_LEN  = 2'd1,
        MODE_SKIP = 2'd2,
        MODE_DONE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_EOL     = 2'd1,
        ST_NOBYTES = 2'd2,
        ST_LIMIT   = 2'd3
    } status_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] opt_byte;
        logic       last;
        logic       area_empty;
    } item_t;

endpackage

`default_nettype wire

>>> rtl/spf_in_stage.sv
// input register stage for option bytes
`timescale 1ns / 1ps
`default_nettype none

module spf_in_stage (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  wire  [7:0]        s_tdata,
    input  wire               s_tlast,
    input  wire               s_tuser,
    input  wire               consume,
    output spf_pkg::item_t    item
);
    import spf_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       empty_reg;
    logic       load;

    assign s_tready = !valid_reg || consume;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg  <= s_tdata;
            last_reg  <= s_tlast;
            empty_reg <= s_tuser;
        end
    end

    assign item = '{valid: valid_reg, opt_byte: byte_reg, last: last_reg,
                    area_empty: empty_reg};

endmodule

`default_nettype wire

>>> rtl/spf_parser.sv
// option walk state and result register
`timescale 1ns / 1ps
`default_nettype none

module spf_parser #(
    parameter int MAX_OPTIONS   = 16,
    parameter int SPA_OPT_BYTES = 16,
    parameter int AREA_BYTES    = 40
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  spf_pkg::item_t    item,
    output logic              consume,
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [15:0]       m_tdata   // found, spa_offset[5:0], status[1:0], zero pad
);
    import spf_pkg::*;

    localparam int CNT_W = $clog2(MAX_OPTIONS + 1);
    localparam int POS_W = $clog2(AREA_BYTES + 1);

    mode_t               mode_reg, mode_next;
    logic [SKIP_W-1:0]   skip_reg, skip_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    off_reg, off_next;
    status_t             hst_reg, hst_next;

    logic                m_valid_reg, m_valid_next;
    logic [15:0]         m_data_reg;

    logic                out_free;
    logic                emit;
    status_t             res_status;
    logic [15:0]         res_data;
    logic                cnt_full;
    logic                cnt_full_next;

    assign out_free = !m_valid_reg || m_tready;
    assign consume  = item.valid && out_free;
    assign cnt_full = cnt_reg >= CNT_W'(MAX_OPTIONS);

    // next state of the option walk
    always_comb begin
        mode_next = mode_reg;
        skip_next = skip_reg;
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        off_next  = off_reg;
        hst_next  = hst_reg;
        if (pos_reg < POS_W'(AREA_BYTES)) begin
            pos_next = pos_reg + 1'b1;
            unique case (mode_reg)
                MODE_KIND: begin
                    if (cnt_full) begin
                        mode_next = MODE_DONE;
                        hst_next  = ST_LIMIT;
                        skip_next = '0;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                        if (item.opt_byte == KIND_SPA) begin
                            off_next  = pos_reg;
                            mode_next = MODE_DONE;
                            skip_next = SKIP_W'(SPA_OPT_BYTES - 1);
                            hst_next  = (SPA_OPT_BYTES == 1) ? ST_FOUND : ST_NOBYTES;
                        end else if (item.opt_byte == KIND_NOP) begin
                            mode_next = MODE_KIND;
                        end else if (item.opt_byte == KIND_EOL) begin
                            mode_next = MODE_DONE;
                            hst_next  = ST_EOL;
                            skip_next = '0;
                        end else if (item.last) begin
                            mode_next = MODE_DONE;
                            hst_next  = ST_NOBYTES;
                            skip_next = '0;
                        end else begin
                            mode_next = MODE_LEN;
                        end
                    end
                end
                MODE_LEN: begin
                    if (item.opt_byte == 8'd0) begin
                        mode_next = MODE_DONE;
                        hst_next  = ST_LIMIT;
                        skip_next = '0;
                    end else if (item.opt_byte == 8'd1) begin
                        if (cnt_full) begin
                            mode_next = MODE_DONE;
                            hst_next  = ST_LIMIT;
                            skip_next = '0;
                        end else begin
                            cnt_next  = cnt_reg + 1'b1;
                            mode_next = MODE_KIND;
                        end
                    end else begin
                        skip_next = item.opt_byte - 8'd2;
                        mode_next = (item.opt_byte == 8'd2) ? MODE_KIND : MODE_SKIP;
                    end
                end
                MODE_SKIP: begin
                    if (skip_reg > 1) begin
                        skip_next = skip_reg - 1'b1;
                    end else begin
                        skip_next = '0;
                        mode_next = MODE_KIND;
                    end
                end
                MODE_DONE: begin
                    if (skip_reg != '0) begin
                        skip_next = skip_reg - 1'b1;
                        if (skip_reg == SKIP_W'(1)) begin
                            hst_next = ST_FOUND;
                        end
                    end
                end
                default: begin
                    mode_next = MODE_KIND;
                end
            endcase
        end
    end

    assign cnt_full_next = cnt_next >= CNT_W'(MAX_OPTIONS);

    // result of the transfer, if any
    always_comb begin
        emit       = item.area_empty || item.last;
        res_status = ST_NOBYTES;
        if (!item.area_empty) begin
            if (mode_next == MODE_DONE) begin
                res_status = hst_next;
            end else if (mode_next == MODE_LEN) begin
                res_status = ST_NOBYTES;
            end else begin
                res_status = cnt_full_next ? ST_LIMIT : ST_NOBYTES;
            end
        end
        res_data       = '0;
        res_data[0]    = (res_status == ST_FOUND);
        res_data[6:1]  = (res_status == ST_FOUND) ? OFFSET_W'(off_next) : '0;
        res_data[8:7]  = res_status;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (consume && emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_KIND;
            skip_reg    <= '0;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            off_reg     <= '0;
            hst_reg     <= ST_NOBYTES;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (consume) begin
                if (emit) begin
                    mode_reg <= MODE_KIND;
                    skip_reg <= '0;
                    cnt_reg  <= '0;
                    pos_reg  <= '0;
                    off_reg  <= '0;
                    hst_reg  <= ST_NOBYTES;
                end else begin
                    mode_reg <= mode_next;
                    skip_reg <= skip_next;
                    cnt_reg  <= cnt_next;
                    pos_reg  <= pos_next;
                    off_reg  <= off_next;
                    hst_reg  <= hst_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && emit) begin
            m_data_reg <= res_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

>>> rtl/tcp_option_spa_finder.sv
// top level of the tcp option spa finder
`timescale 1ns / 1ps
`default_nettype none

// Takes the TCP option area one byte per transfer (tlast on the final byte,
// tuser for an empty area) and returns one result per area: found flag, byte
// offset of a complete kind 253 option and a status (found, end of list, out
// of bytes, option limit). One byte is taken every cycle while the output is
// not stalled; the per-byte update of the option walk lies between the input
// register and the result register, so m_tvalid rises once the last byte has
// passed from the input register through the option walk and the result has
// been loaded into the result register.
module tcp_option_spa_finder #(
    parameter int MAX_OPTIONS   = 16,
    parameter int SPA_OPT_BYTES = 16,
    parameter int AREA_BYTES    = 40
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // opt_byte[7:0]
    input  wire         s_tlast,
    input  wire         s_tuser,    // area_empty
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata     // found, spa_offset[5:0], status[1:0], zero pad
);
    import spf_pkg::*;

    item_t item;
    logic  consume;

    spf_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .consume  (consume),
        .item     (item)
    );

    spf_parser #(
        .MAX_OPTIONS   (MAX_OPTIONS),
        .SPA_OPT_BYTES (SPA_OPT_BYTES),
        .AREA_BYTES    (AREA_BYTES)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (item),
        .consume  (consume),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/spf_checker.sv
// port checks for the tcp option spa finder and their bind
`timescale 1ns / 1ps
`default_nettype none

module spf_checker #(
    parameter int SPA_OPT_BYTES = 16,
    parameter int AREA_BYTES    = 40
) (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata
);
    import spf_pkg::*;

    // stalled result transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // found flag agrees with status
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[8:7] == ST_FOUND)))
        else $error("found flag and status disagree");

    // offset is zero unless found
    a_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == 6'd0)
        else $error("offset set without found");

    // a found option lies wholly inside the area
    a_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |->
            (32'(m_tdata[6:1]) + 32'(SPA_OPT_BYTES) <= 32'(AREA_BYTES)))
        else $error("found option does not fit the area");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tcp_option_spa_finder spf_checker #(
    .SPA_OPT_BYTES (SPA_OPT_BYTES),
    .AREA_BYTES    (AREA_BYTES)
) u_spf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
